/* rtl/core/fbrd_pkg.sv */
package fbrd_pkg;

  localparam int FRAME_WIDTH  = 320;
  localparam int FRAME_HEIGHT = 240;
  localparam int STORE_SIZE   = FRAME_WIDTH * FRAME_HEIGHT;

  // Frame store address; one bit minimum for a single-pixel frame
  localparam int ADDR_W = (STORE_SIZE > 1) ? $clog2(STORE_SIZE) : 1;

  // Coordinate width holds the larger dimension itself (clip bound)
  localparam int MAX_DIM = (FRAME_WIDTH > FRAME_HEIGHT) ? FRAME_WIDTH : FRAME_HEIGHT;
  localparam int COORD_W = $clog2(MAX_DIM + 1);

  localparam int COUNT_W = 17;
  localparam logic [COUNT_W-1:0] FILL_COUNT = COUNT_W'(STORE_SIZE);

  typedef enum logic [2:0] {
    OP_FILL    = 3'd0,
    OP_PIXEL   = 3'd1,
    OP_HLINE   = 3'd2,
    OP_VLINE   = 3'd3,
    OP_OUTLINE = 3'd4,
    OP_RECT    = 3'd5,
    OP_READ    = 3'd6,
    OP_NONE    = 3'd7
  } opcode_t;

  typedef struct packed {
    opcode_t            opcode;
    logic signed [15:0] x_pos;
    logic signed [15:0] y_pos;
    logic signed [15:0] span_w;
    logic signed [15:0] span_h;
    logic [15:0]        color;
  } cmd_t;

  typedef struct packed {
    logic [15:0]        pixel_value;
    logic [COUNT_W-1:0] pixels_written;
  } res_t;

  // One straight run of pixels: fixed row (horizontal) or column (vertical)
  typedef struct packed {
    logic               horiz;
    logic               fix_chk;
    logic signed [15:0] fix;
    logic signed [15:0] start;
    logic signed [15:0] len;
  } run_t;

  typedef struct packed {
    logic               active;
    logic [COORD_W-1:0] lo;
    logic [COORD_W-1:0] hi;
    logic [COORD_W-1:0] fix;
  } clip_t;

endpackage

/* rtl/core/fbrd_ram.sv */
module fbrd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/core/fbrd_clip.sv */
module fbrd_clip
  import fbrd_pkg::*;
(
  input  run_t  run,
  output clip_t res
);

  localparam logic signed [17:0] LIM_W = 18'(FRAME_WIDTH);
  localparam logic signed [17:0] LIM_H = 18'(FRAME_HEIGHT);

  logic signed [17:0] lim_span, lim_fix;
  logic signed [17:0] start_x, len_x, fix_x, end_pos, lo_x, hi_x;
  logic               fix_ok, len_pos;

  always_comb begin
    lim_span = run.horiz ? LIM_W : LIM_H;
    lim_fix  = run.horiz ? LIM_H : LIM_W;
    start_x  = 18'(run.start);
    len_x    = 18'(run.len);
    fix_x    = 18'(run.fix);
    // span end in full precision, no wrap
    end_pos  = start_x + len_x;
    lo_x     = start_x[17] ? 18'sd0 : start_x;
    hi_x     = (end_pos > lim_span) ? lim_span : end_pos;
    len_pos  = !run.len[15] && (run.len != 16'sd0);
    fix_ok   = !run.fix_chk || (!fix_x[17] && (fix_x < lim_fix));
    res.active = len_pos && fix_ok && (lo_x < hi_x);
    res.lo     = lo_x[COORD_W-1:0];
    res.hi     = hi_x[COORD_W-1:0];
    res.fix    = fix_x[COORD_W-1:0];
  end

endmodule

/* rtl/core/framebuffer_rect_draw_clipped_unit.sv */
// Sequence: a run is clipped in S_SETUP, addressed in S_ADDR and drawn in S_DRAW, a fully
//   clipped one ends in S_SETUP; rectangles clip rows in S_ROWS, reads use S_RD and S_RDW.
// Throughput: about one pixel write per cycle, set by the single frame store write port.
// Fill-all sweeps the whole store in the clearing state, then strobes done.
// Reset: synchronous; a clearing pass over the whole store zeroes it with busy high.
//   done pulses one cycle per item; the receiver cannot stall.
module framebuffer_rect_draw_clipped_unit
  import fbrd_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  cmd_t cmd,
  output logic busy,
  output logic done,
  output res_t result
);

  typedef enum logic [8:0] {
    S_CLEAR = 9'b000000001,
    S_IDLE  = 9'b000000010,
    S_ROWS  = 9'b000000100,
    S_SETUP = 9'b000001000,
    S_ADDR  = 9'b000010000,
    S_DRAW  = 9'b000100000,
    S_RD    = 9'b001000000,
    S_RDW   = 9'b010000000,
    S_DONE  = 9'b100000000
  } state_t;

  state_t             state, state_next;
  cmd_t               cmd_q;
  logic [1:0]         run_idx;
  logic [COORD_W-1:0] row, row_hi, pos, hi, fix;
  logic               horiz;
  logic [ADDR_W-1:0]  addr;
  logic [COUNT_W-1:0] count;
  logic [15:0]        value;
  logic               fill_cmd;

  run_t               run;
  clip_t              clip;
  logic [COORD_W-1:0] pos_inc, row_inc, mul_row, mul_col;
  logic [ADDR_W-1:0]  prod, step;
  logic               accept, last_clear, run_end, w_pos;
  logic               ram_we;
  logic [15:0]        ram_wdata, ram_rdata;

  assign accept     = start && (state == S_IDLE);
  assign pos_inc    = pos + 1'b1;
  assign row_inc    = row + 1'b1;
  assign last_clear = (addr == ADDR_W'(STORE_SIZE - 1));
  assign w_pos      = !cmd_q.span_w[15] && (cmd_q.span_w != 16'sd0);
  // Current run is finished: either fully clipped away or its last pixel is written
  assign run_end    = ((state == S_SETUP) && !clip.active) ||
                      ((state == S_DRAW) && (pos_inc == hi));

  // Build the descriptor of the run the sequencer is working on
  always_comb begin
    run = '0;
    case (cmd_q.opcode)
      OP_PIXEL, OP_READ: begin
        run = '{horiz: 1'b1, fix_chk: 1'b1, fix: cmd_q.y_pos, start: cmd_q.x_pos,
                len: 16'sd1};
      end
      OP_HLINE: begin
        run = '{horiz: 1'b1, fix_chk: 1'b1, fix: cmd_q.y_pos, start: cmd_q.x_pos,
                len: cmd_q.span_w};
      end
      OP_VLINE: begin
        run = '{horiz: 1'b0, fix_chk: 1'b1, fix: cmd_q.x_pos, start: cmd_q.y_pos,
                len: cmd_q.span_h};
      end
      OP_OUTLINE: begin
        // top, bottom, left, right; the far edges wrap to 16 bits
        case (run_idx)
          2'd0: run = '{horiz: 1'b1, fix_chk: 1'b1, fix: cmd_q.y_pos,
                        start: cmd_q.x_pos, len: cmd_q.span_w};
          2'd1: run = '{horiz: 1'b1, fix_chk: 1'b1,
                        fix: cmd_q.y_pos + cmd_q.span_h - 16'sd1,
                        start: cmd_q.x_pos, len: cmd_q.span_w};
          2'd2: run = '{horiz: 1'b0, fix_chk: 1'b1, fix: cmd_q.x_pos,
                        start: cmd_q.y_pos, len: cmd_q.span_h};
          default: run = '{horiz: 1'b0, fix_chk: 1'b1,
                           fix: cmd_q.x_pos + cmd_q.span_w - 16'sd1,
                           start: cmd_q.y_pos, len: cmd_q.span_h};
        endcase
      end
      OP_RECT: begin
        if (state == S_ROWS) begin
          // clip the row range alone, no fixed coordinate
          run = '{horiz: 1'b0, fix_chk: 1'b0, fix: 16'sd0, start: cmd_q.y_pos,
                  len: cmd_q.span_h};
        end else begin
          run = '{horiz: 1'b1, fix_chk: 1'b1, fix: 16'(row), start: cmd_q.x_pos,
                  len: cmd_q.span_w};
        end
      end
      default: run = '0;
    endcase
  end

  // Shared clip unit: one wide add and the bound compares for every run
  fbrd_clip u_clip (
    .run (run),
    .res (clip)
  );

  // Start address of a run: row * FRAME_WIDTH + column
  assign mul_row = horiz ? fix : pos;
  assign mul_col = horiz ? pos : fix;
  assign prod    = ADDR_W'(mul_row) * ADDR_W'(FRAME_WIDTH);
  assign step    = horiz ? ADDR_W'(1) : ADDR_W'(FRAME_WIDTH);

  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: begin
        if (last_clear) begin
          state_next = fill_cmd ? S_DONE : S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          case (cmd.opcode)
            OP_FILL:  state_next = S_CLEAR;
            OP_RECT:  state_next = S_ROWS;
            OP_NONE:  state_next = S_DONE;
            default:  state_next = S_SETUP;
          endcase
        end
      end
      S_ROWS: begin
        state_next = (clip.active && w_pos) ? S_SETUP : S_DONE;
      end
      S_SETUP: begin
        if (clip.active) begin
          state_next = S_ADDR;
        end
      end
      S_ADDR: begin
        state_next = (cmd_q.opcode == OP_READ) ? S_RD : S_DRAW;
      end
      // Hold while the run is written; its end is handled below
      S_DRAW:  state_next = S_DRAW;
      S_RD:    state_next = S_RDW;
      S_RDW:   state_next = S_DONE;
      S_DONE:  state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
    // Advance to the next run, the next row, or finish
    if (run_end) begin
      if (cmd_q.opcode == OP_RECT) begin
        state_next = (row_inc == row_hi) ? S_DONE : S_SETUP;
      end else if ((cmd_q.opcode == OP_OUTLINE) && (run_idx != 2'd3)) begin
        state_next = S_SETUP;
      end else begin
        state_next = S_DONE;
      end
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      addr     <= '0;
      fill_cmd <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        S_IDLE: begin
          if (start) begin
            addr     <= '0;
            fill_cmd <= (cmd.opcode == OP_FILL);
          end
        end
        S_CLEAR: addr <= addr + 1'b1;
        S_ADDR:  addr <= prod + ADDR_W'(mul_col);
        S_DRAW:  addr <= addr + step;
        default: addr <= addr;
      endcase
    end
  end

  // Item datapath
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q   <= cmd;
      run_idx <= 2'd0;
      value   <= '0;
      count   <= (cmd.opcode == OP_FILL) ? FILL_COUNT : '0;
    end
    if (state == S_ROWS) begin
      row    <= clip.lo;
      row_hi <= clip.hi;
    end
    if (state == S_SETUP) begin
      pos   <= clip.lo;
      hi    <= clip.hi;
      fix   <= clip.fix;
      horiz <= run.horiz;
    end
    if (state == S_DRAW) begin
      pos   <= pos_inc;
      count <= count + 1'b1;
    end
    if (state == S_RDW) begin
      value <= ram_rdata;
    end
    if (run_end) begin
      row     <= row_inc;
      run_idx <= run_idx + 1'b1;
    end
  end

  // Frame store: one write port for drawing and clearing, one registered read port
  assign ram_we    = (state == S_CLEAR) || (state == S_DRAW);
  assign ram_wdata = ((state == S_DRAW) || fill_cmd) ? cmd_q.color : 16'h0000;

  fbrd_ram #(
    .WIDTH (16),
    .DEPTH (STORE_SIZE)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (addr),
    .wdata (ram_wdata),
    .raddr (addr),
    .rdata (ram_rdata)
  );

  assign busy                  = (state != S_IDLE);
  assign done                  = (state == S_DONE);
  assign result.pixel_value    = value;
  assign result.pixels_written = count;

`ifndef SYNTHESIS
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted item did not raise busy");

  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe longer than one cycle");

  a_draw_in_store: assert property (@(posedge clk) disable iff (rst)
    (state == S_DRAW) |-> (addr <= ADDR_W'(STORE_SIZE - 1)))
    else $error("pixel write outside the frame store");

  a_read_no_count: assert property (@(posedge clk) disable iff (rst)
    (done && (cmd_q.opcode == OP_READ)) |-> (result.pixels_written == '0))
    else $error("read item reported written pixels");
`endif

endmodule

/* tb/sv/framebuffer_rect_draw_clipped_unit_tb.sv */
module framebuffer_rect_draw_clipped_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import fbrd_pkg::*;

  // Slowest correct run: the clearing pass after reset, a handful of whole-frame
  // commands, and some 400 items, the longest a short but full-width rectangle,
  // with sender gaps. The limit allows several times as much.
  localparam int CYCLE_LIMIT = 10_000_000;
  // Leave ample room after the last result for stray strobes.
  localparam int DRAIN_CYCLES = 32;
  localparam int RANDOM_ITEMS = 375;

  // Shadow frame store plus the queue of results the block still owes us.
  class frame_model;
    logic [15:0] pixels [STORE_SIZE];
    res_t        pending_results[$];
    int          errors;

    function new();
      foreach (pixels[i]) pixels[i] = '0;
      errors = 0;
    endfunction

    static function int wrap16(int v);
      return int'($signed(v[15:0]));
    endfunction

    // Paint columns x..x+w-1 of row y, skipping off-frame pixels.
    function int paint_hrun(int x, int y, int w, logic [15:0] color);
      int lo, hi, n;
      n = 0;
      if (w <= 0 || y < 0 || y >= FRAME_HEIGHT) return 0;
      lo = (x < 0) ? 0 : x;
      hi = x + w;
      if (hi > FRAME_WIDTH) hi = FRAME_WIDTH;
      for (int col = lo; col < hi; col++) begin
        pixels[y * FRAME_WIDTH + col] = color;
        n++;
      end
      return n;
    endfunction

    // Paint rows y..y+h-1 of column x, skipping off-frame pixels.
    function int paint_vrun(int x, int y, int h, logic [15:0] color);
      int lo, hi, n;
      n = 0;
      if (h <= 0 || x < 0 || x >= FRAME_WIDTH) return 0;
      lo = (y < 0) ? 0 : y;
      hi = y + h;
      if (hi > FRAME_HEIGHT) hi = FRAME_HEIGHT;
      for (int row = lo; row < hi; row++) begin
        pixels[row * FRAME_WIDTH + x] = color;
        n++;
      end
      return n;
    endfunction

    function void note_command(cmd_t item);
      int x, y, w, h, n, lo, hi;
      logic [15:0] value;
      res_t expected;
      x = int'(item.x_pos);
      y = int'(item.y_pos);
      w = int'(item.span_w);
      h = int'(item.span_h);
      n = 0;
      value = '0;
      case (item.opcode)
        OP_FILL: begin
          foreach (pixels[i]) pixels[i] = item.color;
          n = STORE_SIZE;
        end
        OP_PIXEL: begin
          if (x >= 0 && x < FRAME_WIDTH && y >= 0 && y < FRAME_HEIGHT) begin
            pixels[y * FRAME_WIDTH + x] = item.color;
            n = 1;
          end
        end
        OP_HLINE: n = paint_hrun(x, y, w, item.color);
        OP_VLINE: n = paint_vrun(x, y, h, item.color);
        OP_OUTLINE: begin
          // Corners land twice and count twice; far edges wrap to 16 bits.
          n = paint_hrun(x, y, w, item.color);
          n += paint_hrun(x, wrap16(y + h - 1), w, item.color);
          n += paint_vrun(x, y, h, item.color);
          n += paint_vrun(wrap16(x + w - 1), y, h, item.color);
        end
        OP_RECT: begin
          if (h > 0 && w > 0) begin
            lo = (y < 0) ? 0 : y;
            hi = y + h;
            if (hi > FRAME_HEIGHT) hi = FRAME_HEIGHT;
            for (int row = lo; row < hi; row++) n += paint_hrun(x, row, w, item.color);
          end
        end
        OP_READ: begin
          if (x >= 0 && x < FRAME_WIDTH && y >= 0 && y < FRAME_HEIGHT)
            value = pixels[y * FRAME_WIDTH + x];
        end
        default: ;
      endcase
      expected.pixel_value = value;
      expected.pixels_written = n[COUNT_W-1:0];
      pending_results.push_back(expected);
    endfunction

    function void check_result(res_t got);
      res_t expected;
      if (pending_results.size() == 0) begin
        $display("%0t ns: unexpected result, expected none, actual value %h count %0d",
                 $time, got.pixel_value, got.pixels_written);
        errors++;
        return;
      end
      expected = pending_results.pop_front();
      if (got.pixel_value !== expected.pixel_value) begin
        $display("%0t ns: pixel_value mismatch, expected %h, actual %h",
                 $time, expected.pixel_value, got.pixel_value);
        errors++;
      end
      if (got.pixels_written !== expected.pixels_written) begin
        $display("%0t ns: pixels_written mismatch, expected %0d, actual %0d",
                 $time, expected.pixels_written, got.pixels_written);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic start;
  cmd_t cmd;
  logic busy;
  logic done;
  res_t result;

  frame_model board;
  int cycle_count;
  int big_left;
  logic signed [15:0] last_x;
  logic signed [15:0] last_y;

  framebuffer_rect_draw_clipped_unit uut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done),
    .result (result)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Stop a hung run; the block may never strobe again.
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Take every strobed result at the edge that ends its cycle; values read here
  // are the ones from before the edge.
  always @(posedge clk) begin
    if (!rst && done) board.check_result(result);
  end

  function automatic cmd_t make_cmd(opcode_t op, int x, int y, int w, int h,
                                    logic [15:0] color);
    cmd_t item;
    item.opcode = op;
    item.x_pos  = 16'(x);
    item.y_pos  = 16'(y);
    item.span_w = 16'(w);
    item.span_h = 16'(h);
    item.color  = color;
    return item;
  endfunction

  // Most coordinates sit near the frame so that clipping on both sides is hit;
  // one item in ten uses the whole 16-bit range.
  function automatic cmd_t random_command();
    cmd_t item;
    int pick;
    bit wide;
    wide = ($urandom_range(0, 9) == 0);
    item.color  = 16'($urandom);
    item.x_pos  = wide ? 16'($urandom) : 16'(int'($urandom_range(0, 359)) - 20);
    item.y_pos  = wide ? 16'($urandom) : 16'(int'($urandom_range(0, 279)) - 20);
    item.span_w = wide ? 16'($urandom) : 16'(int'($urandom_range(0, 44)) - 4);
    item.span_h = wide ? 16'($urandom) : 16'(int'($urandom_range(0, 44)) - 4);
    pick = $urandom_range(0, 99);
    if (pick < 2 && big_left > 0) begin
      // Whole-frame fills are slow; allow only a couple.
      item.opcode = OP_FILL;
      big_left--;
    end else if (pick < 16) begin
      item.opcode = OP_PIXEL;
    end else if (pick < 30) begin
      item.opcode = OP_HLINE;
    end else if (pick < 44) begin
      item.opcode = OP_VLINE;
    end else if (pick < 58) begin
      item.opcode = OP_OUTLINE;
    end else if (pick < 70) begin
      item.opcode = OP_RECT;
      // Keep wide rectangles short so one item cannot sweep the frame.
      if (wide)
        item.span_h = $urandom_range(0, 1) ? 16'(-int'($urandom_range(1, 32768)))
                                           : 16'($urandom_range(0, 12));
    end else if (pick < 96) begin
      item.opcode = OP_READ;
      // Read back where something was just drawn, half the time.
      if ($urandom_range(0, 1)) begin
        item.x_pos = last_x + 16'($urandom_range(0, 3));
        item.y_pos = last_y + 16'($urandom_range(0, 3));
      end
    end else begin
      item.opcode = OP_NONE;
    end
    if (item.opcode != OP_READ && item.opcode != OP_NONE) begin
      last_x = item.x_pos;
      last_y = item.y_pos;
    end
    return item;
  endfunction

  // Present one item from a falling edge and hold it until the block takes it;
  // then maybe drop start for a random gap. Returns at a falling edge.
  task automatic send_command(cmd_t item, int idle_pct);
    start <= 1'b1;
    cmd   <= item;
    do @(posedge clk); while (busy);
    board.note_command(item);
    @(negedge clk);
    if ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      do @(negedge clk); while ($urandom_range(0, 99) < idle_pct);
    end
  endtask

  initial begin
    cmd_t item;
    int idle_pct;
    board    = new();
    big_left = 2;
    last_x   = '0;
    last_y   = '0;
    rst      = 1'b1;
    start    = 1'b0;
    cmd      = '0;
    repeat (7) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part: edges of the frame, every opcode, wrap and clip cases.
    // The first item waits out the clearing pass through busy.
    send_command(make_cmd(OP_READ, 0, 0, 0, 0, 16'h0000), 6);
    send_command(make_cmd(OP_PIXEL, 0, 0, 0, 0, 16'hFFFF), 6);
    send_command(make_cmd(OP_PIXEL, 319, 239, 0, 0, 16'h1234), 6);
    send_command(make_cmd(OP_PIXEL, 320, 0, 0, 0, 16'hBEEF), 6);
    send_command(make_cmd(OP_PIXEL, -1, 5, 0, 0, 16'hBEEF), 6);
    send_command(make_cmd(OP_PIXEL, -32768, 32767, 32767, -32768, 16'hFFFF), 6);
    send_command(make_cmd(OP_READ, 0, 0, 0, 0, 16'h0000), 6);
    send_command(make_cmd(OP_READ, 319, 239, -1, -1, 16'hFFFF), 6);
    send_command(make_cmd(OP_READ, -1, 0, 0, 0, 16'h0000), 6);
    send_command(make_cmd(OP_HLINE, -5, 10, 20, 0, 16'h0F0F), 6);
    // Run whose columns pass the top of the 16-bit range.
    send_command(make_cmd(OP_HLINE, 32760, 3, 32767, 0, 16'h00FF), 6);
    send_command(make_cmd(OP_HLINE, 0, 0, 0, 5, 16'h7777), 6);
    send_command(make_cmd(OP_HLINE, 0, 0, -32768, 5, 16'h7777), 6);
    send_command(make_cmd(OP_VLINE, 5, -3, 0, 300, 16'hF00F), 6);
    send_command(make_cmd(OP_VLINE, 5, 0, 4, 0, 16'hF00F), 6);
    // Negative height still draws both horizontal edges.
    send_command(make_cmd(OP_OUTLINE, 10, 10, 5, -3, 16'hAAAA), 6);
    // Far edges wrap to negative coordinates.
    send_command(make_cmd(OP_OUTLINE, 32767, 32767, 2, 2, 16'h5555), 6);
    // One-pixel outline: the same pixel counted four times.
    send_command(make_cmd(OP_OUTLINE, 100, 100, 1, 1, 16'hC3C3), 6);
    send_command(make_cmd(OP_RECT, -10, -10, 30, 20, 16'h3C3C), 6);
    // Rows past the top of the 16-bit range do not wrap; they stay off frame.
    send_command(make_cmd(OP_RECT, 0, 32760, 10, 32767, 16'h1111), 6);
    send_command(make_cmd(OP_RECT, 0, 0, 0, 10, 16'h1111), 6);
    send_command(make_cmd(OP_NONE, 1, 1, 1, 1, 16'hFFFF), 6);
    send_command(make_cmd(OP_FILL, -1, -1, -1, -1, 16'hA5A5), 6);
    send_command(make_cmd(OP_READ, 160, 120, 0, 0, 16'h0000), 6);
    send_command(make_cmd(OP_RECT, 0, 0, 320, 240, 16'h5A5A), 6);
    send_command(make_cmd(OP_READ, 319, 0, 0, 0, 16'h0000), 6);

    // Random part: sender idles lightly, then heavily, then not at all.
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      idle_pct = (i < RANDOM_ITEMS / 3) ? 6 : ((i < 2 * RANDOM_ITEMS / 3) ? 63 : 0);
      item = random_command();
      send_command(item, idle_pct);
    end
    start <= 1'b0;

    // Drain: wait for every owed result, then watch for stray strobes.
    while (board.pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
